// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the echo ranger RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define UER_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ultrasonic_echo_ranger: assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define UER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ultrasonic_echo_ranger: assertion failed");

`endif

// ===== rtl/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// uer_pkg
// Types and constants shared by the echo ranger modules.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned DIST_W      = 23;
	localparam int unsigned PRE_LOW_TICKS = 5;
	// The product of ticks and speed carries 16 fraction bits plus one for the halving.
	localparam int unsigned DIST_SHIFT  = 9;
	localparam int unsigned THR_SHIFT   = 17;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_PULSE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RISE_TIMEOUT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CM_PER_TICK   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OBST_THRESH   = 3'd4;

	typedef struct packed {
		logic [7:0]  trigger_pulse_ticks;
		logic [15:0] rise_timeout_ticks;
		logic [15:0] echo_timeout_ticks;
		logic [15:0] cm_per_tick_q16;
		logic [9:0]  obstacle_threshold_cm;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		trigger_pulse_ticks:   8'd10,
		rise_timeout_ticks:    16'd10000,
		echo_timeout_ticks:    16'd30000,
		cm_per_tick_q16:       16'd2248,
		obstacle_threshold_cm: 10'd20
	};

	typedef struct packed {
		logic              trigger_level;
		logic              busy_res;
		logic              measure_done;
		logic              timed_out;
		logic [DIST_W-1:0] distance_q8;
		logic              obstacle;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/uer_fsm.sv =====
// ----------------------------------------------------------------------------
// uer_fsm
// Measurement sequencer: trigger timing, echo timing and distance result.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_fsm import uer_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire logic action,
	input  wire logic echo_level,
	input  wire cfg_t cfg,
	output res_t      res
);

	localparam int CW    = COUNT_WIDTH;
	localparam int CMP_W = (CW > 16) ? CW : 16;
	localparam int PW    = CW + 16;
	localparam int EW    = (PW > 32) ? PW : 32;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_LOW  = 3'd1,
		PH_HIGH = 3'd2,
		PH_WAIT = 3'd3,
		PH_ECHO = 3'd4
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [CW-1:0]   count_q, count_d;
	res_t            res_q, res_d;

	logic [CW-1:0]   count_inc;
	logic            count_full;
	logic [7:0]      pulse;
	logic [PW-1:0]   prod;
	logic [EW-1:0]   prod_x;
	logic [EW-1:0]   thr_x;
	logic            dist_sat;

	assign count_full = (count_q == {CW{1'b1}});
	assign count_inc  = count_full ? count_q : count_q + CW'(1);
	assign pulse      = (cfg.trigger_pulse_ticks == 8'd0) ? 8'd1 : cfg.trigger_pulse_ticks;

	assign prod     = PW'(count_q) * PW'(cfg.cm_per_tick_q16);
	assign prod_x   = EW'(prod);
	assign thr_x    = EW'(cfg.obstacle_threshold_cm) << THR_SHIFT;
	assign dist_sat = (prod_x >> 32) != '0;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		res_d   = '0;
		unique case (phase_q)
			PH_IDLE: begin
				if (action) begin
					res_d.busy_res = 1'b1;
					count_d        = CW'(1);
					phase_d        = PH_LOW;
				end
			end
			PH_LOW: begin
				res_d.busy_res = 1'b1;
				if (count_inc >= CW'(PRE_LOW_TICKS)) begin
					phase_d = PH_HIGH;
					count_d = '0;
				end else begin
					count_d = count_inc;
				end
			end
			PH_HIGH: begin
				res_d.busy_res      = 1'b1;
				res_d.trigger_level = 1'b1;
				if (count_inc >= CW'(pulse)) begin
					phase_d = PH_WAIT;
					count_d = '0;
				end else begin
					count_d = count_inc;
				end
			end
			PH_WAIT: begin
				if (echo_level) begin
					res_d.busy_res = 1'b1;
					count_d        = CW'(1);
					phase_d        = PH_ECHO;
				end else if (CMP_W'(count_inc) > CMP_W'(cfg.rise_timeout_ticks) ||
						count_inc == {CW{1'b1}}) begin
					res_d.measure_done = 1'b1;
					res_d.timed_out    = 1'b1;
					phase_d            = PH_IDLE;
					count_d            = '0;
				end else begin
					res_d.busy_res = 1'b1;
					count_d        = count_inc;
				end
			end
			PH_ECHO: begin
				if (echo_level) begin
					if (CMP_W'(count_inc) > CMP_W'(cfg.echo_timeout_ticks) ||
							count_inc == {CW{1'b1}}) begin
						res_d.measure_done = 1'b1;
						res_d.timed_out    = 1'b1;
						phase_d            = PH_IDLE;
						count_d            = '0;
					end else begin
						res_d.busy_res = 1'b1;
						count_d        = count_inc;
					end
				end else begin
					// Echo fell: count_q holds the high time in ticks.
					res_d.distance_q8  = dist_sat ? {DIST_W{1'b1}} :
						prod_x[DIST_W+DIST_SHIFT-1:DIST_SHIFT];
					res_d.obstacle     = (prod_x <= thr_x);
					res_d.measure_done = 1'b1;
					phase_d            = PH_IDLE;
					count_d            = '0;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				count_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			res_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			res_q   <= res_d;
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

// ===== rtl/ultrasonic_echo_ranger.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Echo pulse ranger: one request per microsecond tick, one result per request.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   action, echo_level
// out      output     out_valid / out_ready trigger_level, busy_res, measure_done,
//                                           timed_out, distance_q8, obstacle
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request is taken every cycle while out_ready is high; its result passes
// through the input stage, then the sequencer and result register.
// The distance multiply and threshold compare sit in the sequencer stage.
// Reset loads the default register values and returns the sequencer to idle.
// While out_ready is low the result holds, one more request waits in the
// input stage, and in_ready then drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ultrasonic_echo_ranger import uer_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  action,
	input  wire logic                  echo_level,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       trigger_level,
	output logic                       busy_res,
	output logic                       measure_done,
	output logic                       timed_out,
	output logic [DIST_W-1:0]          distance_q8,
	output logic                       obstacle,

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	logic valid_s1;
	logic action_s1;
	logic echo_s1;
	logic out_valid_q;
	logic advance;
	res_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TRIGGER_PULSE: cfg_q.trigger_pulse_ticks   <= cfg_data[7:0];
				CFG_RISE_TIMEOUT:  cfg_q.rise_timeout_ticks    <= cfg_data;
				CFG_ECHO_TIMEOUT:  cfg_q.echo_timeout_ticks    <= cfg_data;
				CFG_CM_PER_TICK:   cfg_q.cm_per_tick_q16       <= cfg_data;
				CFG_OBST_THRESH:   cfg_q.obstacle_threshold_cm <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// The input stage moves on whenever the result register is free or being taken.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			echo_s1   <= echo_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	uer_fsm #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.action     (action_s1),
		.echo_level (echo_s1),
		.cfg        (cfg_q),
		.res        (res)
	);

	assign out_valid     = out_valid_q;
	assign trigger_level = res.trigger_level;
	assign busy_res      = res.busy_res;
	assign measure_done  = res.measure_done;
	assign timed_out     = res.timed_out;
	assign distance_q8   = res.distance_q8;
	assign obstacle      = res.obstacle;

	`UER_ASSERT_IMPLIES(a_done_not_busy, clk, arst_n,
		out_valid && measure_done, !busy_res)
	`UER_ASSERT_IMPLIES(a_timeout_with_done, clk, arst_n,
		out_valid && timed_out, measure_done && !trigger_level)
	`UER_ASSERT_IMPLIES(a_distance_on_success, clk, arst_n,
		out_valid && (obstacle || distance_q8 != '0), measure_done && !timed_out)
	`UER_ASSERT_NEXT(a_stage_moves_to_output, clk, arst_n,
		advance, out_valid)

endmodule

`default_nettype wire
